// ----- design/sapq_pkg.sv -----
// sapq_pkg: shared codes for the sorted array priority queue
// no dependencies; imported by the top level
`timescale 1ns / 1ps

package sapq_pkg;

    // operation codes carried on the mode field
    localparam logic MODE_ENQ = 1'b0;
    localparam logic MODE_DEQ = 1'b1;

    // result status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    // key and result field widths
    localparam int unsigned KEY_W    = 32;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned OCC_W    = 4;

    typedef logic signed [KEY_W-1:0] t_key;
    typedef logic [STATUS_W-1:0]     t_status;
    typedef logic [OCC_W-1:0]        t_occ;

endpackage

// ----- design/sapq_ram.sv -----
// sapq_ram: generic simple dual port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module sapq_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/sorted_array_priority_queue.sv -----
// sorted_array_priority_queue: a full/empty reject or an enqueue into an empty queue goes
// straight to S_DONE; an enqueue shifts entries up in S_ENQ, a dequeue reads the head in
// S_DEQ_HEAD and shifts entries down in S_DEQ_MOVE. one item is in work at a time; the
// entry ram (one read, one write per cycle) moves one entry per cycle.
// reset (synchronous, active low) empties the queue and drops any pending result;
// the entry ram is not cleared, only entries below the count are ever read.
`timescale 1ns / 1ps

module sorted_array_priority_queue
    import sapq_pkg::*;
#(
    parameter int unsigned DEPTH = 8
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    // input channel
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  logic    i_mode,
    input  t_key    i_value,
    // output channel
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_status o_status,
    output t_key    o_value_out,
    output t_occ    o_occupancy
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    // sequencer states
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_ENQ      = 3'd1;
    localparam logic [2:0] S_ENQ_LAST = 3'd2;
    localparam logic [2:0] S_DEQ_HEAD = 3'd3;
    localparam logic [2:0] S_DEQ_MOVE = 3'd4;
    localparam logic [2:0] S_DONE     = 3'd5;

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_slot, n_slot;
    logic [AW-1:0] r_idx, n_idx;
    t_key          r_key, n_key;
    t_status       r_res_status, n_res_status;
    t_key          r_result, n_result;
    logic          r_out_valid, n_out_valid;
    t_status       r_status, n_status;
    t_key          r_value_out, n_value_out;
    t_occ          r_occ, n_occ;

    // ram port signals
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    t_key          ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [KEY_W-1:0] ram_rdata;
    t_key          rd_key;

    logic [CW-1:0]   count_m1;
    logic [CW-1:0]   idx_p1;
    logic [CW+3:0]   occ_ext;
    logic            out_free;

    assign count_m1 = r_count - CW'(1);
    assign idx_p1   = CW'(r_idx) + CW'(1);
    assign occ_ext  = (CW + 4)'(r_count);
    assign rd_key   = $signed(ram_rdata);
    assign out_free = !r_out_valid || i_out_ready;

    // entry store
    sapq_ram #(
        .WIDTH (KEY_W),
        .DEPTH (DEPTH)
    ) u_entries (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_ready = (r_state == S_IDLE);

    // sequencer: read one entry ahead, compare on enqueue, write back one place over;
    // the read and write addresses differ whenever the read data is used, so no forwarding is needed
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_slot       = r_slot;
        n_idx        = r_idx;
        n_key        = r_key;
        n_res_status = r_res_status;
        n_result     = r_result;
        n_out_valid  = r_out_valid;
        n_status     = r_status;
        n_value_out  = r_value_out;
        n_occ        = r_occ;
        ram_we       = 1'b0;
        ram_waddr    = r_slot;
        ram_wdata    = r_key;
        ram_raddr    = '0;

        // drop the result once its transfer completes
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_key        = i_value;
                    n_result     = '0;
                    n_res_status = STATUS_OK;
                    if (i_mode == MODE_ENQ) begin
                        if (r_count >= CW'(DEPTH)) begin
                            n_res_status = STATUS_FULL;
                            n_state      = S_DONE;
                        end else if (r_count == '0) begin
                            ram_we    = 1'b1;
                            ram_waddr = '0;
                            ram_wdata = i_value;
                            n_count   = r_count + CW'(1);
                            n_state   = S_DONE;
                        end else begin
                            n_slot    = r_count[AW-1:0];
                            ram_raddr = count_m1[AW-1:0];
                            n_state   = S_ENQ;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_res_status = STATUS_EMPTY;
                            n_state      = S_DONE;
                        end else begin
                            ram_raddr = '0;
                            n_state   = S_DEQ_HEAD;
                        end
                    end
                end
            end

            // rd_key holds the entry just below r_slot
            S_ENQ: begin
                ram_we = 1'b1;
                if (rd_key >= r_key) begin
                    ram_waddr = r_slot;
                    ram_wdata = rd_key;
                    n_slot    = r_slot - AW'(1);
                    if (r_slot == AW'(1)) begin
                        n_state = S_ENQ_LAST;
                    end else begin
                        ram_raddr = r_slot - AW'(2);
                    end
                end else begin
                    ram_waddr = r_slot;
                    ram_wdata = r_key;
                    n_count   = r_count + CW'(1);
                    n_state   = S_DONE;
                end
            end

            // new key goes to the bottom slot
            S_ENQ_LAST: begin
                ram_we    = 1'b1;
                ram_waddr = r_slot;
                ram_wdata = r_key;
                n_count   = r_count + CW'(1);
                n_state   = S_DONE;
            end

            // head entry arrives
            S_DEQ_HEAD: begin
                n_result = rd_key;
                if (r_count == CW'(1)) begin
                    n_count = count_m1;
                    n_state = S_DONE;
                end else begin
                    ram_raddr = AW'(1);
                    n_idx     = AW'(1);
                    n_state   = S_DEQ_MOVE;
                end
            end

            // move entry r_idx down one place
            S_DEQ_MOVE: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx - AW'(1);
                ram_wdata = rd_key;
                if (idx_p1 == r_count) begin
                    n_count = count_m1;
                    n_state = S_DONE;
                end else begin
                    n_idx     = r_idx + AW'(1);
                    ram_raddr = r_idx + AW'(1);
                end
            end

            // hand the result to the output register
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_status    = r_res_status;
                    n_value_out = r_result;
                    n_occ       = occ_ext[OCC_W-1:0];
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_slot       <= n_slot;
        r_idx        <= n_idx;
        r_key        <= n_key;
        r_res_status <= n_res_status;
        r_result     <= n_result;
        r_status     <= n_status;
        r_value_out  <= n_value_out;
        r_occ        <= n_occ;
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_value_out = r_value_out;
    assign o_occupancy = r_occ;

endmodule
